// ===== sv/assert_macros.svh =====
// Assertion macros for checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, disabled in reset
`define CHK_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("check failed");
// Next-cycle implication
`define CHK_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("check failed");
`endif

// ===== sv/rbnh_pkg.sv =====
package rbnh_pkg;
  localparam int MaxBoxes = 1024;
  localparam int FracBits = 16;
  localparam int SlotW = $clog2(MaxBoxes);
  localparam int CntW = SlotW + 1;
  localparam logic signed [31:0] QMax = 32'sh7fffffff;
  localparam logic signed [31:0] QMin = 32'sh80000000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_SCAN, ST_DRAIN, ST_OUT
  } state_t;

  localparam logic ActLoad = 1'b0;
  localparam logic ActCast = 1'b1;

  // saturate a 34-bit signed value to 32 bits
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    if (v > 34'(QMax)) return QMax;
    if (v < 34'(QMin)) return QMin;
    return v[31:0];
  endfunction

  // saturate a 64-bit signed value to 32 bits
  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    if (v > 64'(QMax)) return QMax;
    if (v < 64'(QMin)) return QMin;
    return v[31:0];
  endfunction
endpackage

// ===== sv/ray_box_nearest_hit_unit.sv =====
// Loads: result valid the cycle after accept.
// Casts: serial reciprocal (three axes in parallel), then a scan of n = min(box_count,1024)
//   slots at one slot per cycle, a pipeline drain (scan skipped when n is 0), then ST_OUT;
//   the result is registered from ST_OUT.
// One word at a time; input stalls until the held result is taken.
// rst (synchronous) clears box_count and control state; box memory is not cleared.
module ray_box_nearest_hit_unit import rbnh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [10:0] cfg_wdata,
  input  logic in_valid,
  output logic in_stall,
  input  logic action,
  input  logic [9:0] slot,
  input  logic [31:0] entity,
  input  logic signed [31:0] a_x, a_y, a_z, b_x, b_y, b_z, t_start, t_end,
  output logic out_valid,
  input  logic out_stall,
  output logic status,
  output logic hit,
  output logic [31:0] hit_entity,
  output logic signed [31:0] hit_t
);
  localparam int Lat = 7;
  localparam int DivSteps = 2 * FracBits + 2;

  state_t state, state_next;
  logic [10:0] box_count;
  logic signed [31:0] org [3];
  logic signed [31:0] dir [3];
  logic signed [31:0] inv [3];
  logic signed [31:0] lo0, hi0;
  logic [CntW-1:0] scan_cnt, scan_n;
  logic [5:0] div_cnt;
  logic [Lat-1:0] pvld;

  // box memory, one word per slot
  logic [223:0] mem [MaxBoxes];
  logic [223:0] rd;

  // serial divider state: unsigned quotient of 2^(2F) / |d|
  logic [31:0] dabs [3];
  logic [DivSteps:0] rem [3];
  logic [DivSteps-1:0] quo [3];

  logic best_found;
  logic signed [31:0] best_t;
  logic [31:0] best_ent;

  always_ff @(posedge clk) begin
    if (rst) box_count <= '0;
    else if (cfg_we) box_count <= cfg_wdata;
  end

  assign in_stall = (state != ST_IDLE) || out_valid;
  wire acc = in_valid && !in_stall;

  // load path: corners and reject check
  logic rej;
  logic [223:0] wword;
  always_comb begin
    rej = (entity == '0) || b_x[31] || b_y[31] || b_z[31];
    wword = {entity,
             sat34(34'(a_z) + 34'(b_z)), sat34(34'(a_y) + 34'(b_y)),
             sat34(34'(a_x) + 34'(b_x)),
             sat34(34'(a_z) - 34'(b_z)), sat34(34'(a_y) - 34'(b_y)),
             sat34(34'(a_x) - 34'(b_x))};
  end

  always_ff @(posedge clk) begin
    if (acc && action == ActLoad && !rej) mem[slot] <= wword;
    rd <= mem[scan_cnt[SlotW-1:0]];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  logic scan_last;
  assign scan_last = (scan_cnt + 1'b1 >= scan_n);
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (acc) state_next = (action == ActCast) ? ST_DIV : ST_IDLE;
      ST_DIV: if (div_cnt == 6'(DivSteps - 1))
        state_next = (scan_n == '0) ? ST_DRAIN : ST_SCAN;
      ST_SCAN: if (scan_last) state_next = ST_DRAIN;
      ST_DRAIN: if (pvld == '0) state_next = ST_OUT;
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencing, divider and query capture
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
      scan_cnt <= '0;
    end else begin
      if (state == ST_IDLE && acc && action == ActCast) begin
        org[0] <= a_x; org[1] <= a_y; org[2] <= a_z;
        dir[0] <= b_x; dir[1] <= b_y; dir[2] <= b_z;
        dabs[0] <= b_x[31] ? 32'(-b_x) : b_x;
        dabs[1] <= b_y[31] ? 32'(-b_y) : b_y;
        dabs[2] <= b_z[31] ? 32'(-b_z) : b_z;
        lo0 <= t_start; hi0 <= t_end;
        scan_n <= (box_count > 11'(MaxBoxes)) ? CntW'(MaxBoxes) : CntW'(box_count);
        for (int k = 0; k < 3; k++) begin
          rem[k] <= '0; quo[k] <= '0;
        end
        div_cnt <= '0;
        scan_cnt <= '0;
      end
      if (state == ST_DIV) begin
        div_cnt <= div_cnt + 1'b1;
        for (int k = 0; k < 3; k++) begin
          logic [DivSteps:0] r;
          logic nb;
          // dividend 2^(2F), MSB first: its single set bit enters at this step
          nb = (div_cnt == 6'(DivSteps - 1 - 2 * FracBits));
          r = {rem[k][DivSteps-1:0], nb};
          if (r >= (DivSteps+1)'(dabs[k])) begin
            rem[k] <= r - (DivSteps+1)'(dabs[k]);
            quo[k] <= {quo[k][DivSteps-2:0], 1'b1};
          end else begin
            rem[k] <= r;
            quo[k] <= {quo[k][DivSteps-2:0], 1'b0};
          end
        end
      end
      if (state == ST_SCAN) scan_cnt <= scan_cnt + 1'b1;
    end
  end

  // signed, saturated reciprocal from quotient
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [DivSteps+1:0] q;
      q = {2'b00, quo[k]};
      if (dir[k][31]) q = -q;
      if (q > (DivSteps+2)'(QMax)) inv[k] = QMax;
      else if (q < (DivSteps+2)'(QMin)) inv[k] = QMin;
      else inv[k] = q[31:0];
    end
  end

  // scan pipeline
  // s1: read data arrives; diffs. s2: products. s3: slab t per axis.
  // s4-s6: axis reduction. s7: best update.
  logic [31:0] ent1, ent2, ent3, ent4, ent5, ent6;
  logic signed [31:0] d1 [6];
  logic signed [63:0] p2 [6];
  logic signed [31:0] t3 [6];
  logic in3 [3];
  logic zin1 [3], zin2 [3];
  logic signed [31:0] lo4, hi4, lo5, hi5, lo6, hi6;
  logic miss4, miss5, miss6;
  logic signed [31:0] tn3 [3], tf3 [3];

  always_ff @(posedge clk) begin
    if (rst) pvld <= '0;
    else pvld <= {pvld[Lat-2:0], state == ST_SCAN};
  end

  // per-axis t values, kept in flight alongside the reduction
  logic signed [31:0] tn4 [3], tf4 [3], tn5 [3], tf5 [3];
  logic zi4 [3], zi5 [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tn3[k] = (t3[k] > t3[k+3]) ? t3[k+3] : t3[k];
      tf3[k] = (t3[k] > t3[k+3]) ? t3[k] : t3[k+3];
    end
  end
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      tn4[k] <= tn3[k]; tf4[k] <= tf3[k]; zi4[k] <= in3[k];
      tn5[k] <= tn4[k]; tf5[k] <= tf4[k]; zi5[k] <= zi4[k];
    end
  end

  function automatic logic [64:0] axis_step(input logic signed [31:0] l,
      input logic signed [31:0] h, input logic m, input int ax);
    logic signed [31:0] tn, tf, nl, nh;
    logic z, nm;
    case (ax)
      0: begin tn = tn3[0]; tf = tf3[0]; z = in3[0]; end
      1: begin tn = tn4[1]; tf = tf4[1]; z = zi4[1]; end
      default: begin tn = tn5[2]; tf = tf5[2]; z = zi5[2]; end
    endcase
    nl = l; nh = h; nm = m;
    if (dir[ax] == '0) begin
      if (!z) nm = 1'b1;
    end else begin
      if (tn > nl) nl = tn;
      if (tf < nh) nh = tf;
      if (nl > nh) nm = 1'b1;
    end
    return {nl, nh, nm};
  endfunction

  always_ff @(posedge clk) begin
    // stage 1
    ent1 <= rd[223:192];
    for (int k = 0; k < 3; k++) begin
      logic signed [31:0] mn, mx;
      mn = rd[32*k +: 32];
      mx = rd[96 + 32*k +: 32];
      d1[k] <= sat34(34'(mn) - 34'(org[k]));
      d1[k+3] <= sat34(34'(mx) - 34'(org[k]));
      zin1[k] <= (org[k] >= mn) && (org[k] <= mx);
    end
    // stage 2
    ent2 <= ent1;
    for (int k = 0; k < 3; k++) begin
      p2[k] <= 64'(d1[k]) * 64'(inv[k]);
      p2[k+3] <= 64'(d1[k+3]) * 64'(inv[k]);
      zin2[k] <= zin1[k];
    end
    // stage 3
    ent3 <= ent2;
    for (int j = 0; j < 6; j++) t3[j] <= sat64(p2[j] >>> FracBits);
    for (int k = 0; k < 3; k++) in3[k] <= zin2[k];
    // stage 4-6: one axis each
    ent4 <= ent3; ent5 <= ent4; ent6 <= ent5;
    {lo4, hi4, miss4} <= axis_step(lo0, hi0, 1'b0, 0);
    {lo5, hi5, miss5} <= axis_step(lo4, hi4, miss4, 1);
    {lo6, hi6, miss6} <= axis_step(lo5, hi5, miss5, 2);
  end

  // stage 7: nearest-hit tracking; output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      best_found <= 1'b0;
    end else begin
      if (state == ST_DIV) best_found <= 1'b0;
      if (pvld[Lat-1] && !miss6 && (!best_found || lo6 < best_t)) begin
        best_found <= 1'b1;
        best_t <= lo6;
        best_ent <= ent6;
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (acc && action == ActLoad) begin
        out_valid <= 1'b1;
        status <= rej; hit <= 1'b0; hit_entity <= '0; hit_t <= '0;
      end
      if (state == ST_OUT) begin
        out_valid <= 1'b1;
        status <= 1'b0;
        hit <= best_found;
        hit_entity <= best_found ? best_ent : '0;
        hit_t <= best_found ? best_t : '0;
      end
    end
  end
endmodule

// ===== sv/rbnh_checker.sv =====
`include "assert_macros.svh"
module rbnh_checker (
  input logic clk, input logic rst,
  input logic in_valid, input logic in_stall,
  input logic out_valid, input logic out_stall,
  input logic hit, input logic status,
  input logic [31:0] hit_entity, input logic [31:0] hit_t
);
  `CHK_IMP(a_busy_out, clk, rst, out_valid, in_stall)
  `CHK_IMP(a_nohit_zero, clk, rst, out_valid && !hit, hit_t == '0 && hit_entity == '0)
  `CHK_IMP(a_hit_ok, clk, rst, out_valid && hit, !status)
  `CHK_NXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(hit_t))
endmodule

bind ray_box_nearest_hit_unit rbnh_checker u_chk (.*);

// ===== sim/ray_box_nearest_hit_unit_tb.sv =====
module ray_box_nearest_hit_unit_tb;
  import rbnh_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchLimit = 20000;

  // one input word
  typedef struct {
    logic action;
    logic [9:0] slot;
    logic [31:0] entity;
    logic signed [31:0] a[3];
    logic signed [31:0] b[3];
    logic signed [31:0] t_lo;
    logic signed [31:0] t_hi;
  } box_word_t;

  // one result word
  typedef struct {
    logic status;
    logic hit;
    logic [31:0] ent;
    logic signed [31:0] t;
  } hit_word_t;

  // box table mirror, nearest-hit prediction and result check
  class hit_board;
    longint bmin[3][MaxBoxes];
    longint bmax[3][MaxBoxes];
    logic [31:0] bent[MaxBoxes];
    bit written[MaxBoxes];
    int unsigned count;
    hit_word_t pending[$];
    int errors;
    int loads, rejects, casts, hits;

    static function longint clamp(longint v);
      if (v > longint'(QMax)) return longint'(QMax);
      if (v < longint'(QMin)) return longint'(QMin);
      return v;
    endfunction

    static function longint slab(longint corner, longint org, longint inv);
      longint diff;
      diff = clamp(corner - org);
      return clamp((diff * inv) >>> FracBits);
    endfunction

    // length of the written run starting at slot 0
    function int prefix();
      int n;
      n = 0;
      while (n < MaxBoxes && written[n]) n++;
      return n;
    endfunction

    function void note(box_word_t w);
      hit_word_t r;
      longint o[3], d[3], inv[3];
      longint lo, hi, t0, t1, tmp, best;
      bit ok, found;
      int n;
      r = '{default: 0};
      for (int k = 0; k < 3; k++) begin
        o[k] = longint'(w.a[k]);
        d[k] = longint'(w.b[k]);
      end
      if (w.action == ActLoad) begin
        loads++;
        if (w.entity == 0 || d[0] < 0 || d[1] < 0 || d[2] < 0) begin
          r.status = 1'b1;
          rejects++;
        end else begin
          for (int k = 0; k < 3; k++) begin
            bmin[k][w.slot] = clamp(o[k] - d[k]);
            bmax[k][w.slot] = clamp(o[k] + d[k]);
          end
          bent[w.slot] = w.entity;
          written[w.slot] = 1'b1;
        end
      end else begin
        casts++;
        n = (count > MaxBoxes) ? MaxBoxes : int'(count);
        for (int k = 0; k < 3; k++)
          inv[k] = (d[k] != 0) ? clamp((longint'(1) << (2 * FracBits)) / d[k]) : 0;
        found = 1'b0;
        best = 0;
        for (int i = 0; i < n; i++) begin
          lo = longint'(w.t_lo);
          hi = longint'(w.t_hi);
          ok = 1'b1;
          for (int k = 0; k < 3 && ok; k++) begin
            if (d[k] == 0) begin
              // flat axis: origin must sit inside the slab
              if (o[k] < bmin[k][i] || o[k] > bmax[k][i]) ok = 1'b0;
            end else begin
              t0 = slab(bmin[k][i], o[k], inv[k]);
              t1 = slab(bmax[k][i], o[k], inv[k]);
              if (t0 > t1) begin
                tmp = t0;
                t0 = t1;
                t1 = tmp;
              end
              if (t0 > lo) lo = t0;
              if (t1 < hi) hi = t1;
              if (lo > hi) ok = 1'b0;
            end
          end
          // strict compare keeps the earliest slot on ties
          if (ok && (!found || lo < best)) begin
            found = 1'b1;
            best = lo;
            r.ent = bent[i];
          end
        end
        if (found) begin
          r.hit = 1'b1;
          r.t = best[31:0];
          hits++;
        end
      end
      pending.insert(pending.size(), r);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check(hit_word_t got);
      hit_word_t exp;
      if (pending.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status)
        report($sformatf("status got %0b want %0b", got.status, exp.status));
      if (got.hit !== exp.hit)
        report($sformatf("hit got %0b want %0b", got.hit, exp.hit));
      if (got.ent !== exp.ent)
        report($sformatf("hit_entity got %h want %h", got.ent, exp.ent));
      if (got.t !== exp.t)
        report($sformatf("hit_t got %h want %h", got.t, exp.t));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = 1'b0;
  logic [9:0] slot = '0;
  logic [31:0] entity = '0;
  logic signed [31:0] a_x = '0, a_y = '0, a_z = '0, b_x = '0, b_y = '0, b_z = '0;
  logic signed [31:0] t_start = '0, t_end = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic status, hit;
  logic [31:0] hit_entity;
  logic signed [31:0] hit_t;

  hit_board board = new();
  int send_idle = 0;
  int recv_idle = 0;
  int quiet_cycles = 0;

  ray_box_nearest_hit_unit uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .action(action), .slot(slot),
    .entity(entity), .a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y),
    .b_z(b_z), .t_start(t_start), .t_end(t_end), .out_valid(out_valid),
    .out_stall(out_stall), .status(status), .hit(hit), .hit_entity(hit_entity),
    .hit_t(hit_t)
  );

  always #1 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check('{status: status, hit: hit, ent: hit_entity, t: hit_t});
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send(input box_word_t w);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    action <= w.action;
    slot <= w.slot;
    entity <= w.entity;
    a_x <= w.a[0];
    a_y <= w.a[1];
    a_z <= w.a[2];
    b_x <= w.b[0];
    b_y <= w.b[1];
    b_z <= w.b[2];
    t_start <= w.t_lo;
    t_end <= w.t_hi;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note(w);
  endtask

  // write box_count once the block has drained
  task automatic set_count(input int unsigned n);
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= n[10:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    board.count = n;
  endtask

  function automatic box_word_t mk_load(int s, logic [31:0] ent,
      longint cx, longint cy, longint cz, longint hx, longint hy, longint hz);
    box_word_t w;
    w.action = ActLoad;
    w.slot = s[9:0];
    w.entity = ent;
    w.a = '{cx[31:0], cy[31:0], cz[31:0]};
    w.b = '{hx[31:0], hy[31:0], hz[31:0]};
    w.t_lo = $urandom;
    w.t_hi = $urandom;
    return w;
  endfunction

  function automatic box_word_t mk_cast(longint ox, longint oy, longint oz,
      longint dx, longint dy, longint dz, longint t0, longint t1);
    box_word_t w;
    w.action = ActCast;
    w.slot = $urandom;
    w.entity = $urandom;
    w.a = '{ox[31:0], oy[31:0], oz[31:0]};
    w.b = '{dx[31:0], dy[31:0], dz[31:0]};
    w.t_lo = t0[31:0];
    w.t_hi = t1[31:0];
    return w;
  endfunction

  function automatic longint rs(int mag);
    return longint'($urandom_range(2 * mag)) - mag;
  endfunction

  // random load: mostly sane boxes, some rejects and raw noise
  function automatic box_word_t rand_load(int max_slot);
    box_word_t w;
    int s, kind;
    s = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(max_slot);
    kind = $urandom_range(99);
    w = mk_load(s, $urandom_range(32'hffff_ffff, 1), rs(20 << 16), rs(20 << 16),
                rs(20 << 16), $urandom_range(5 << 16), $urandom_range(5 << 16),
                $urandom_range(5 << 16));
    if (kind < 6) w.entity = 0;
    else if (kind < 12) w.b[$urandom_range(2)] = -$urandom_range(1, 1 << 20);
    else if (kind < 20) begin
      w.a = '{$urandom, $urandom, $urandom};
      w.b = '{$urandom, $urandom, $urandom};
    end
    return w;
  endfunction

  // random cast: mostly rays into the box cloud, some raw noise
  function automatic box_word_t rand_cast();
    box_word_t w;
    w = mk_cast(rs(30 << 16), rs(30 << 16), rs(30 << 16), rs(2 << 16), rs(2 << 16),
                rs(2 << 16), rs(1 << 16), longint'($urandom_range(100 << 16)));
    for (int k = 0; k < 3; k++)
      if ($urandom_range(5) == 0) w.b[k] = 0;
    if ($urandom_range(9) == 0) begin
      w.a = '{$urandom, $urandom, $urandom};
      w.b = '{$urandom, $urandom, $urandom};
      w.t_lo = $urandom;
      w.t_hi = $urandom;
    end
    return w;
  endfunction

  task automatic random_run(input int n);
    int lim;
    for (int i = 0; i < n; i++) begin
      if (i % 30 == 0) begin
        lim = board.prefix();
        set_count($urandom_range(lim < 48 ? lim : 48));
      end
      if ($urandom_range(1)) send(rand_cast());
      else send(rand_load(40));
    end
  endtask

  localparam longint One = 1 << 16;

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: table fill, rejects, saturation, empty scan
    send(mk_load(0, 32'h0000_0001, 0, 0, 10 * One, One, One, One));
    send(mk_load(1, 32'hffff_ffff, 0, 0, 10 * One, One, One, One));
    send(mk_load(2, 32'h0000_0003, 0, 0, 5 * One, 2 * One, 2 * One, One));
    send(mk_load(3, 32'h8000_0000, QMax, QMax, QMax, QMax, QMax, QMax));
    send(mk_load(4, 32'h0000_0005, QMin, QMin, QMin, QMax, QMax, QMax));
    send(mk_load(5, 32'h0000_0006, 3 * One, -3 * One, 20 * One, 0, 0, 0));
    send(mk_load(6, 0, 0, 0, 0, One, One, One));
    send(mk_load(6, 32'h7, 0, 0, 0, -1, One, One));
    send(mk_load(6, 32'h7, 0, 0, 0, One, QMin, One));
    send(mk_load(6, 32'h7, 0, 0, 0, One, One, -One));
    send(mk_load(6, 32'h0000_0007, -4 * One, 4 * One, 30 * One, One, One, One));
    send(mk_load(7, 32'h0000_0008, 0, 0, -10 * One, One, One, One));
    send(mk_load(1023, 32'h0000_0009, 0, 0, 0, One, One, One));
    send(mk_cast(0, 0, 0, 0, 0, One, 0, 100 * One));

    // directed casts over the first eight slots
    set_count(8);
    send(mk_cast(0, 0, 0, 0, 0, One, 0, 100 * One));
    send(mk_cast(0, 0, 0, 0, 0, -One, -(100 * One), 100 * One));
    send(mk_cast(0, 0, 10 * One, 0, 0, 0, 0, One));
    send(mk_cast(5 * One, 5 * One, 0, 0, 0, One, 0, 100 * One));
    send(mk_cast(0, 0, 0, 0, 0, One, 50 * One, One));
    send(mk_cast(0, 0, 0, 1, -1, QMax, QMin, QMax));
    send(mk_cast(0, 0, 0, QMin, QMax, 1, QMin, QMax));
    send(mk_cast(3 * One, -3 * One, 0, 0, 0, One >> 3, 0, QMax));
    send(mk_cast(0, 0, 0, 0, 0, 0, 5 * One, One));
    send(mk_cast(QMax, QMax, QMax, -One, -One, -One, QMin, QMax));

    // random: receiver idles heavily (sender lightly), then sender heavily (receiver lightly), then neither
    send_idle = 7;
    recv_idle = 56;
    random_run(190);
    send_idle = 56;
    recv_idle = 7;
    random_run(190);
    send_idle = 0;
    recv_idle = 0;
    random_run(166);

    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d loads (%0d rejected) and %0d casts, %0d of them hits",
             board.loads, board.rejects, board.casts, board.hits);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
